// ===== rtl/pst_pkg.sv =====
// Shared types and field widths for the Prim spanning tree unit.
`timescale 1ns / 1ps
`default_nettype none

package pst_pkg;

	localparam int VERTEX_W      = 5;
	localparam int WEIGHT_W      = 16;
	localparam int VCOUNT_W      = 6;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RELAX,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic first_pass;
	} relax_ctl_t;

	typedef struct packed {
		logic done;
		logic found;
	} relax_sts_t;

endpackage

`default_nettype wire

// ===== rtl/prim_spanning_tree_unit.sv =====
// Prim minimum spanning tree unit: top level with load control and result register.
// Items load one per cycle into a symmetric adjacency memory, one entry per
// vertex pair, which is undefined until written and gets no clearing pass.
// The item with load_done starts a run from vertex 0 over n vertices (the
// vertex_count register clamped to 2..MAX_VERTICES) that delivers n-1 tree
// edges. Each edge is set by one relax pass that reads the distance memory and
// an adjacency row one entry per cycle; input is stalled for the whole run. A
// finished edge waits in the output register while the next pass runs.
`timescale 1ns / 1ps
`default_nettype none

module prim_spanning_tree_unit #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pst_pkg::VCOUNT_W-1:0]     cfg_vertex_count,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [pst_pkg::VERTEX_W-1:0]     vertex_a,
	input  logic [pst_pkg::VERTEX_W-1:0]     vertex_b,
	input  logic [pst_pkg::WEIGHT_W-1:0]     edge_weight,
	input  logic                             no_edge,
	input  logic                             load_done,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [pst_pkg::VERTEX_W-1:0]     parent_vertex,
	output logic [pst_pkg::VERTEX_W-1:0]     joined_vertex,
	output logic [pst_pkg::WEIGHT_W-1:0]     tree_edge_weight,
	output logic                             unreachable,
	output logic                             last_edge
);
	import pst_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int DW = WEIGHT_BITS + 1;
	localparam logic [MAX_VERTICES-1:0] ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	state_t state_q, state_d;

	logic [VCOUNT_W-1:0]      vc_q;
	logic [6:0]               vc_ext, n_full;
	logic [NW-1:0]            n;
	logic [VW-1:0]            pick_q, pick_d, pick_sel;
	logic [MAX_VERTICES-1:0]  in_tree_q, in_tree_d;
	logic [NW-1:0]            count_q, count_d;
	logic                     last_step, out_load;

	logic                     in_range, adj_wr_en;
	logic [DW-1:0]            adj_wr_data, adj_rdata;
	logic [VW-1:0]            rd_k;

	relax_ctl_t               relax_ctl;
	relax_sts_t               relax_sts;
	logic [VW-1:0]            cand_vertex, cand_parent, free_vertex;
	logic [WEIGHT_BITS-1:0]   cand_weight;

	logic                     out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VCOUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vc_q <= cfg_vertex_count;
		end
	end

	always_comb begin
		vc_ext = {1'b0, vc_q};
		if (vc_ext < 7'd2) begin
			n_full = 7'd2;
		end else if (vc_ext > 7'(MAX_VERTICES)) begin
			n_full = 7'(MAX_VERTICES);
		end else begin
			n_full = vc_ext;
		end
		n = NW'(n_full);
	end

	assign in_range = ({2'b00, vertex_a} < 7'(MAX_VERTICES)) &&
		({2'b00, vertex_b} < 7'(MAX_VERTICES));
	assign adj_wr_data = no_edge ? {1'b1, {WEIGHT_BITS{1'b0}}} :
		{1'b0, WEIGHT_BITS'(edge_weight)};

	pst_adj_store #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_adj (
		.clk    (clk),
		.wr_en  (adj_wr_en),
		.wr_a   (VW'(vertex_a)),
		.wr_b   (VW'(vertex_b)),
		.wr_data(adj_wr_data),
		.rd_a   (pick_q),
		.rd_b   (rd_k),
		.rd_data(adj_rdata)
	);

	pst_relax #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_relax (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (relax_ctl),
		.n          (n),
		.pick       (pick_q),
		.in_tree    (in_tree_q),
		.adj_rdata  (adj_rdata),
		.rd_k       (rd_k),
		.sts        (relax_sts),
		.cand_vertex(cand_vertex),
		.cand_parent(cand_parent),
		.cand_weight(cand_weight),
		.free_vertex(free_vertex)
	);

	assign pick_sel  = relax_sts.found ? cand_vertex : free_vertex;
	assign last_step = (count_q + NW'(2)) == n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pick_d    = pick_q;
		in_tree_d = in_tree_q;
		count_d   = count_q;
		relax_ctl = '0;
		out_load  = 1'b0;
		in_stall  = 1'b1;
		adj_wr_en = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (in_valid) begin
					adj_wr_en = in_range;
					if (load_done) begin
						relax_ctl.start      = 1'b1;
						relax_ctl.first_pass = 1'b1;
						pick_d    = '0;
						in_tree_d = ONE;
						count_d   = '0;
						state_d   = ST_RELAX;
					end
				end
			end
			ST_RELAX: begin
				if (relax_sts.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					count_d  = count_q + NW'(1);
					if (last_step) begin
						state_d = ST_LOAD;
					end else begin
						in_tree_d       = in_tree_q | (ONE << pick_sel);
						pick_d          = pick_sel;
						relax_ctl.start = 1'b1;
						state_d         = ST_RELAX;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_q      <= '0;
			in_tree_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pick_q    <= pick_d;
			in_tree_q <= in_tree_d;
			count_q   <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			parent_vertex    <= relax_sts.found ? VERTEX_W'(cand_parent) : '0;
			joined_vertex    <= VERTEX_W'(pick_sel);
			tree_edge_weight <= relax_sts.found ? WEIGHT_W'(cand_weight) : '0;
			unreachable      <= !relax_sts.found;
			last_edge        <= last_step;
		end
	end

	assign out_valid = out_valid_q;

	a_done_in_relax: assert property (@(posedge clk) disable iff (!arst_n)
		relax_sts.done |-> state_q == ST_RELAX)
		else $error("relax pass finished outside a run");

	a_pick_unvisited: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !in_tree_q[pick_sel])
		else $error("joined vertex already in tree");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELAX |-> (count_q + NW'(2)) <= n)
		else $error("edge count ran past vertex count");

	a_run_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_step |=> state_q == ST_LOAD)
		else $error("run continued after last edge");

endmodule

`default_nettype wire

// ===== rtl/pst_adj_store.sv =====
// Adjacency memory holding one entry per unordered vertex pair.
`timescale 1ns / 1ps
`default_nettype none

module pst_adj_store #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int DW = WEIGHT_BITS + 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [VW-1:0] wr_a,
	input  logic [VW-1:0] wr_b,
	input  logic [DW-1:0] wr_data,
	input  logic [VW-1:0] rd_a,
	input  logic [VW-1:0] rd_b,
	output logic [DW-1:0] rd_data
);
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] ROW = AW'(MAX_VERTICES);

	logic [DW-1:0] mem [DEPTH];
	logic [VW-1:0] wr_lo, wr_hi, rd_lo, rd_hi;
	logic [AW-1:0] wr_addr, rd_addr;

	always_comb begin
		wr_lo = (wr_a < wr_b) ? wr_a : wr_b;
		wr_hi = (wr_a < wr_b) ? wr_b : wr_a;
		rd_lo = (rd_a < rd_b) ? rd_a : rd_b;
		rd_hi = (rd_a < rd_b) ? rd_b : rd_a;
		wr_addr = AW'(wr_lo) * ROW + AW'(wr_hi);
		rd_addr = AW'(rd_lo) * ROW + AW'(rd_hi);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/pst_relax.sv =====
// Distance memory with one relax-and-select pass over the active vertices.
`timescale 1ns / 1ps
`default_nettype none

module pst_relax #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int NW = $clog2(MAX_VERTICES + 1),
	localparam int DW = WEIGHT_BITS + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pst_pkg::relax_ctl_t      ctl,
	input  logic [NW-1:0]            n,
	input  logic [VW-1:0]            pick,
	input  logic [MAX_VERTICES-1:0]  in_tree,
	input  logic [DW-1:0]            adj_rdata,
	output logic [VW-1:0]            rd_k,
	output pst_pkg::relax_sts_t      sts,
	output logic [VW-1:0]            cand_vertex,
	output logic [VW-1:0]            cand_parent,
	output logic [WEIGHT_BITS-1:0]   cand_weight,
	output logic [VW-1:0]            free_vertex
);
	import pst_pkg::*;

	localparam int EW = DW + VW;
	localparam logic [DW-1:0] INF = {1'b1, {WEIGHT_BITS{1'b0}}};

	logic [EW-1:0] work_mem [MAX_VERTICES];

	logic          busy_q, first_q, done_q;
	logic [VW-1:0] k_q;
	logic          issue_last;
	logic          v_s1, last_s1;
	logic [VW-1:0] k_s1;
	logic [EW-1:0] cur_s1;

	logic [DW-1:0] e, cur_best, new_best;
	logic [VW-1:0] cur_par, new_par;
	logic          free, upd, better;

	logic [DW-1:0] min_q;
	logic [VW-1:0] cand_q, cand_par_q, free_q;
	logic          free_seen_q;

	assign issue_last = (NW'(k_q) + NW'(1)) == n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			k_s1    <= '0;
			done_q  <= 1'b0;
		end else begin
			if (ctl.start) begin
				busy_q  <= 1'b1;
				k_q     <= '0;
				first_q <= ctl.first_pass;
			end else if (busy_q) begin
				k_q <= k_q + VW'(1);
				if (issue_last) begin
					busy_q <= 1'b0;
				end
			end
			v_s1    <= busy_q;
			last_s1 <= busy_q && issue_last;
			k_s1    <= k_q;
			done_q  <= v_s1 && last_s1;
		end
	end

	always_comb begin
		e        = (k_s1 == pick) ? INF : adj_rdata;
		cur_best = cur_s1[EW-1:VW];
		cur_par  = cur_s1[VW-1:0];
		free     = !in_tree[k_s1];
		upd      = first_q || (free && (e < cur_best));
		new_best = upd ? e : cur_best;
		new_par  = upd ? pick : cur_par;
		better   = v_s1 && free && (new_best < min_q);
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			cur_s1 <= work_mem[k_q];
		end
		if (v_s1) begin
			work_mem[k_s1] <= {new_best, new_par};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= INF;
			cand_q      <= '0;
			cand_par_q  <= '0;
			free_seen_q <= 1'b0;
			free_q      <= '0;
		end else if (ctl.start) begin
			min_q       <= INF;
			free_seen_q <= 1'b0;
		end else begin
			if (better) begin
				min_q      <= new_best;
				cand_q     <= k_s1;
				cand_par_q <= new_par;
			end
			if (v_s1 && free && !free_seen_q) begin
				free_seen_q <= 1'b1;
				free_q      <= k_s1;
			end
		end
	end

	assign rd_k        = k_q;
	assign sts.done    = done_q;
	assign sts.found   = !min_q[WEIGHT_BITS];
	assign cand_vertex = cand_q;
	assign cand_parent = cand_par_q;
	assign cand_weight = min_q[WEIGHT_BITS-1:0];
	assign free_vertex = free_q;

endmodule

`default_nettype wire

// ===== test/pst_tree_checker.sv =====
// Checker for the Prim spanning tree unit: mirrors the graph, predicts tree edges, compares.
`timescale 1ns / 1ps

module pst_tree_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [pst_pkg::VCOUNT_W-1:0]  cfg_vertex_count,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [pst_pkg::VERTEX_W-1:0]  vertex_a,
	input  logic [pst_pkg::VERTEX_W-1:0]  vertex_b,
	input  logic [pst_pkg::WEIGHT_W-1:0]  edge_weight,
	input  logic                          no_edge,
	input  logic                          load_done,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [pst_pkg::VERTEX_W-1:0]  parent_vertex,
	input  logic [pst_pkg::VERTEX_W-1:0]  joined_vertex,
	input  logic [pst_pkg::WEIGHT_W-1:0]  tree_edge_weight,
	input  logic                          unreachable,
	input  logic                          last_edge,
	output int                            mismatches,
	output int                            edges_pending
);

	localparam int NV = 32;
	localparam logic [pst_pkg::WEIGHT_W:0] INF_DIST = {1'b1, {pst_pkg::WEIGHT_W{1'b0}}};

	typedef struct packed {
		logic [pst_pkg::VERTEX_W-1:0] parent;
		logic [pst_pkg::VERTEX_W-1:0] joined;
		logic [pst_pkg::WEIGHT_W-1:0] weight;
		logic                         unreach;
		logic                         last;
	} tree_edge_t;

	logic [pst_pkg::WEIGHT_W:0]   adj_copy [NV][NV];
	logic [pst_pkg::VCOUNT_W-1:0] vcount_reg;
	tree_edge_t                   tree_edges_due [$];

	function automatic logic [pst_pkg::WEIGHT_W:0] edge_cost(int a, int b);
		if (a == b)
			return INF_DIST;
		return adj_copy[a][b];
	endfunction

	function automatic void plan_tree(int n);
		logic [pst_pkg::WEIGHT_W:0]   key_cost [NV];
		bit                           joined [NV];
		logic [pst_pkg::VERTEX_W-1:0] via [NV];
		logic [pst_pkg::WEIGHT_W:0]   best;
		logic [pst_pkg::WEIGHT_W:0]   cost;
		int                           pick;
		bit                           found;
		tree_edge_t                   te;
		for (int k = 0; k < NV; k++) begin
			key_cost[k] = (k < n) ? edge_cost(0, k) : INF_DIST;
			joined[k]   = 1'b0;
			via[k]      = '0;
		end
		joined[0] = 1'b1;
		for (int s = 0; s + 1 < n; s++) begin
			best  = INF_DIST;
			pick  = 0;
			found = 1'b0;
			for (int k = 0; k < n; k++) begin
				if (!joined[k] && key_cost[k] < best) begin
					best  = key_cost[k];
					pick  = k;
					found = 1'b1;
				end
			end
			if (found) begin
				te.parent  = via[pick];
				te.weight  = best[pst_pkg::WEIGHT_W-1:0];
				te.unreach = 1'b0;
			end else begin
				for (int k = n - 1; k >= 0; k--)
					if (!joined[k])
						pick = k;
				te.parent  = '0;
				te.weight  = '0;
				te.unreach = 1'b1;
			end
			te.joined = pick[pst_pkg::VERTEX_W-1:0];
			te.last   = (s + 2 == n);
			tree_edges_due.push_back(te);
			joined[pick] = 1'b1;
			for (int k = 0; k < n; k++) begin
				cost = edge_cost(pick, k);
				if (!joined[k] && cost < key_cost[k]) begin
					key_cost[k] = cost;
					via[k]      = pick[pst_pkg::VERTEX_W-1:0];
				end
			end
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int         n;
		tree_edge_t want;
		if (!arst_n) begin
			vcount_reg = pst_pkg::VCOUNT_RESET;
			tree_edges_due.delete();
			mismatches    = 0;
			edges_pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tree_edges_due.size() == 0) begin
					$error("tree edge transaction with nothing predicted");
					mismatches++;
				end else begin
					want = tree_edges_due.pop_front();
					check_field("parent_vertex", want.parent, parent_vertex);
					check_field("joined_vertex", want.joined, joined_vertex);
					check_field("tree_edge_weight", want.weight, tree_edge_weight);
					check_field("unreachable", want.unreach, unreachable);
					check_field("last_edge", want.last, last_edge);
				end
			end
			if (cfg_valid && cfg_ready)
				vcount_reg = cfg_vertex_count;
			if (in_valid && !in_stall) begin
				adj_copy[vertex_a][vertex_b] = no_edge ? INF_DIST : {1'b0, edge_weight};
				adj_copy[vertex_b][vertex_a] = no_edge ? INF_DIST : {1'b0, edge_weight};
				if (load_done) begin
					n = int'(vcount_reg);
					if (n < 2)
						n = 2;
					if (n > NV)
						n = NV;
					plan_tree(n);
				end
			end
			edges_pending = tree_edges_due.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the Prim spanning tree unit: clock, reset, graph stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

	typedef enum int {
		WG_FULL,
		WG_TIES,
		WG_SPARSE,
		WG_EMPTY
	} weight_mode_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [pst_pkg::VCOUNT_W-1:0]  cfg_vertex_count;
	logic                          in_valid;
	logic                          in_stall;
	logic [pst_pkg::VERTEX_W-1:0]  vertex_a;
	logic [pst_pkg::VERTEX_W-1:0]  vertex_b;
	logic [pst_pkg::WEIGHT_W-1:0]  edge_weight;
	logic                          no_edge;
	logic                          load_done;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [pst_pkg::VERTEX_W-1:0]  parent_vertex;
	logic [pst_pkg::VERTEX_W-1:0]  joined_vertex;
	logic [pst_pkg::WEIGHT_W-1:0]  tree_edge_weight;
	logic                          unreachable;
	logic                          last_edge;
	int                            mismatches;
	int                            edges_pending;

	bit wrote [32][32];
	bit steady = 1'b0;
	int items_sent = 0;

	always #6 clk = ~clk;

	prim_spanning_tree_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_vertex_count (cfg_vertex_count),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.vertex_a         (vertex_a),
		.vertex_b         (vertex_b),
		.edge_weight      (edge_weight),
		.no_edge          (no_edge),
		.load_done        (load_done),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.parent_vertex    (parent_vertex),
		.joined_vertex    (joined_vertex),
		.tree_edge_weight (tree_edge_weight),
		.unreachable      (unreachable),
		.last_edge        (last_edge)
	);

	pst_tree_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_vertex_count (cfg_vertex_count),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.vertex_a         (vertex_a),
		.vertex_b         (vertex_b),
		.edge_weight      (edge_weight),
		.no_edge          (no_edge),
		.load_done        (load_done),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.parent_vertex    (parent_vertex),
		.joined_vertex    (joined_vertex),
		.tree_edge_weight (tree_edge_weight),
		.unreachable      (unreachable),
		.last_edge        (last_edge),
		.mismatches       (mismatches),
		.edges_pending    (edges_pending)
	);

	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 23);
	end

	task automatic send_pair(input logic [4:0] a, input logic [4:0] b,
			input logic [15:0] w, input logic ne, input logic ld);
		while (!steady && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		vertex_a    <= a;
		vertex_b    <= b;
		edge_weight <= w;
		no_edge     <= ne;
		load_done   <= ld;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		wrote[a][b] = 1'b1;
		wrote[b][a] = 1'b1;
		items_sent++;
	endtask

	task automatic set_vertex_count(input logic [5:0] v);
		in_valid <= 1'b0;
		while (edges_pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		cfg_valid        <= 1'b1;
		cfg_vertex_count <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic draw_edge(input weight_mode_t m, output logic [15:0] w, output logic ne);
		int r;
		r = $urandom_range(99);
		case (m)
			WG_FULL: begin
				w  = (r < 5) ? 16'h0000 : (r < 10) ? 16'hffff : 16'($urandom);
				ne = ($urandom_range(99) < 5);
			end
			WG_TIES: begin
				w  = 16'($urandom_range(3));
				ne = ($urandom_range(99) < 10);
			end
			WG_SPARSE: begin
				w  = 16'($urandom);
				ne = ($urandom_range(99) < 75);
			end
			default: begin
				w  = 16'($urandom);
				ne = 1'b1;
			end
		endcase
	endtask

	task automatic build_graph(input int n, input weight_mode_t m, input int body,
			input bit rewrite);
		logic [4:0]  a;
		logic [4:0]  b;
		logic [15:0] w;
		logic        ne;
		for (int i = 0; i < body; i++) begin
			if ($urandom_range(99) < 10) begin
				a = 5'($urandom_range(31));
				b = 5'($urandom_range(31));
			end else begin
				a = 5'($urandom_range(n - 1));
				b = 5'($urandom_range(n - 1));
			end
			draw_edge(m, w, ne);
			send_pair(a, b, w, ne, 1'b0);
		end
		for (int i = 0; i < n; i++) begin
			for (int j = i + 1; j < n; j++) begin
				if (rewrite || !wrote[i][j]) begin
					draw_edge(m, w, ne);
					if ($urandom_range(1))
						send_pair(5'(i), 5'(j), w, ne, 1'b0);
					else
						send_pair(5'(j), 5'(i), w, ne, 1'b0);
				end
			end
		end
		if ($urandom_range(99) < 10) begin
			a = 5'($urandom_range(31));
			b = 5'($urandom_range(31));
		end else begin
			a = 5'($urandom_range(n - 1));
			b = ($urandom_range(99) < 15) ? a : 5'($urandom_range(n - 1));
		end
		draw_edge(m, w, ne);
		send_pair(a, b, w, ne, 1'b1);
	endtask

	initial begin
		int           small_start;
		int           graph_no;
		int           r;
		logic [5:0]   cfg_val;
		int           n_eff;
		weight_mode_t mode;
		bit           rewrite;
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_vertex_count = '0;
		in_valid         = 1'b0;
		vertex_a         = '0;
		vertex_b         = '0;
		edge_weight      = '0;
		no_edge          = 1'b0;
		load_done        = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// two-vertex graphs: weight extremes, missing edge, diagonal write
		set_vertex_count(6'd2);
		send_pair(5'd0, 5'd1, 16'h0000, 1'b0, 1'b1);
		send_pair(5'd1, 5'd0, 16'hffff, 1'b0, 1'b1);
		send_pair(5'd0, 5'd1, 16'd123, 1'b1, 1'b1);
		send_pair(5'd1, 5'd1, 16'd500, 1'b0, 1'b1);
		set_vertex_count(6'd0);
		send_pair(5'd0, 5'd1, 16'd9, 1'b0, 1'b1);
		set_vertex_count(6'd1);
		send_pair(5'd31, 5'd30, 16'haaaa, 1'b0, 1'b0);
		send_pair(5'd1, 5'd0, 16'd77, 1'b0, 1'b1);

		// all weights tied
		set_vertex_count(6'd4);
		send_pair(5'd0, 5'd1, 16'd5, 1'b0, 1'b0);
		send_pair(5'd0, 5'd2, 16'd5, 1'b0, 1'b0);
		send_pair(5'd0, 5'd3, 16'd5, 1'b0, 1'b0);
		send_pair(5'd1, 5'd2, 16'd5, 1'b0, 1'b0);
		send_pair(5'd1, 5'd3, 16'd5, 1'b0, 1'b0);
		send_pair(5'd2, 5'd3, 16'd5, 1'b0, 1'b1);

		// disconnected graph with two unreachable joins
		set_vertex_count(6'd5);
		send_pair(5'd0, 5'd1, 16'd3, 1'b0, 1'b0);
		send_pair(5'd0, 5'd2, 16'd1, 1'b1, 1'b0);
		send_pair(5'd0, 5'd3, 16'd1, 1'b1, 1'b0);
		send_pair(5'd0, 5'd4, 16'd1, 1'b1, 1'b0);
		send_pair(5'd1, 5'd2, 16'd1, 1'b1, 1'b0);
		send_pair(5'd1, 5'd3, 16'd1, 1'b1, 1'b0);
		send_pair(5'd1, 5'd4, 16'd1, 1'b1, 1'b0);
		send_pair(5'd2, 5'd3, 16'd4, 1'b0, 1'b0);
		send_pair(5'd2, 5'd4, 16'd1, 1'b1, 1'b0);
		send_pair(5'd3, 5'd4, 16'd1, 1'b1, 1'b1);

		// full-size graph, register above range
		set_vertex_count(6'd63);
		build_graph(32, WG_FULL, 24, 1'b0);

		small_start = items_sent;
		graph_no    = 0;
		while (items_sent - small_start < 280) begin
			steady = (graph_no >= 10 && graph_no < 16);
			r = $urandom_range(99);
			if (r < 4)
				cfg_val = 6'($urandom_range(63, 32));
			else if (r < 8)
				cfg_val = 6'($urandom_range(1));
			else
				cfg_val = 6'($urandom_range(9, 2));
			n_eff = (cfg_val < 2) ? 2 : (cfg_val > 32) ? 32 : cfg_val;
			r = $urandom_range(99);
			if (r < 40)
				mode = WG_FULL;
			else if (r < 70)
				mode = WG_TIES;
			else if (r < 92)
				mode = WG_SPARSE;
			else
				mode = WG_EMPTY;
			rewrite = (mode == WG_SPARSE) || (mode == WG_EMPTY) || ($urandom_range(99) < 30);
			if (n_eff == 32) begin
				rewrite = 1'b0;
				mode    = WG_TIES;
			end
			set_vertex_count(cfg_val);
			build_graph(n_eff, mode, $urandom_range(2 * n_eff), rewrite);
			graph_no++;
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		while (edges_pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
		if (mismatches == 0 && edges_pending == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
